FILE: rtl/scsm_pkg.sv
// Shared widths, register map and types for the series cell stack monitor.
package scsm_pkg;

    localparam int SAMPLE_BITS    = 10;
    localparam int CELL_BITS      = SAMPLE_BITS + 1;
    localparam int NUM_CELLS      = 4;
    localparam int STORE_DEPTH    = NUM_CELLS - 1;
    localparam int RESULT_BITS    = NUM_CELLS * CELL_BITS + SAMPLE_BITS + 5;
    localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

    localparam int APB_ADDR_BITS  = 4;
    localparam int APB_DATA_BITS  = 32;

    localparam logic [1:0] REG_BALANCE = 2'd0;
    localparam logic [1:0] REG_OVER    = 2'd1;
    localparam logic [1:0] REG_UNDER   = 2'd2;

    localparam logic [SAMPLE_BITS-1:0] BALANCE_RESET = SAMPLE_BITS'(226);
    localparam logic [SAMPLE_BITS-1:0] OVER_RESET    = SAMPLE_BITS'(248);
    localparam logic [CELL_BITS-1:0]   UNDER_RESET   = CELL_BITS'(559);

    localparam logic [1:0] LAST_TAP = 2'(NUM_CELLS - 1);

    typedef struct packed {
        logic [CELL_BITS-1:0]   under_level;
        logic [SAMPLE_BITS-1:0] over_level;
        logic [SAMPLE_BITS-1:0] balance_level;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0]                 stack_level;
        logic [NUM_CELLS-1:0][CELL_BITS-1:0]    cells;
    } cell_set_t;

    // First member lands in the top bits, so the bottom cell sits at bit 0.
    typedef struct packed {
        logic                   under_voltage;
        logic                   over_voltage;
        logic [1:0]             balance_cell;
        logic                   balance_active;
        logic [SAMPLE_BITS-1:0] stack_level;
        logic [CELL_BITS-1:0]   cell_four;
        logic [CELL_BITS-1:0]   cell_three;
        logic [CELL_BITS-1:0]   cell_two;
        logic [CELL_BITS-1:0]   cell_one;
    } result_t;

endpackage

FILE: rtl/series_cell_stack_monitor_top.sv
// Top level of the four-cell series stack monitor.
//
//  port group | direction | beat contents
//  -----------+-----------+---------------------------------------------------
//  s_axis     | in        | one stack tap reading, taps 0..3 in order
//  m_axis     | out       | cell values, stack level, balance and fault flags
//  apb        | in/out    | balance, over and under levels
//
// A tap beat is taken every cycle while the cell-set register is free or
// draining. The fourth tap loads the cell set; the compares then load the
// result register once it is free or draining. Sustained rate is one tap
// per cycle while m_axis is not stalled. Reset clears the tap counter and
// valid flags and loads the reset levels. A stalled m_axis holds its beat;
// s_tready drops only when both the cell set and the result register are full.
module series_cell_stack_monitor_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [scsm_pkg::IN_TDATA_BITS-1:0]  s_tdata,   // [9:0] tap_sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [10:0] cell_one, [21:11] cell_two, [32:22] cell_three, [43:33] cell_four,
    // [53:44] stack_level, [54] balance_active, [56:55] balance_cell,
    // [57] over_voltage, [58] under_voltage
    output logic [scsm_pkg::OUT_TDATA_BITS-1:0] m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [scsm_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [scsm_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [scsm_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    scsm_pkg::cfg_t      cfg;
    scsm_pkg::cell_set_t cell_set;
    scsm_pkg::result_t   result;
    logic                set_valid;
    logic                set_take;

    scsm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    scsm_collect u_collect (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tap_valid  (s_tvalid),
        .tap_ready  (s_tready),
        .tap_sample (s_tdata[scsm_pkg::SAMPLE_BITS-1:0]),
        .set_take   (set_take),
        .set_valid  (set_valid),
        .cell_set   (cell_set)
    );

    scsm_judge u_judge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .set_valid (set_valid),
        .set_take  (set_take),
        .cell_set  (cell_set),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .result    (result)
    );

    assign m_tdata = scsm_pkg::OUT_TDATA_BITS'(result);

`ifndef SYNTHESIS
    // An unmarked result reports cell zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !result.balance_active) |-> (result.balance_cell == 2'd0))
        else $error("balance_cell set without balance_active");

    // A cell set waiting with a free result register must move on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (set_valid && !m_tvalid) |=> m_tvalid)
        else $error("cell set not moved into free result register");

    // No input beat while both stages are full and the output stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (set_valid && m_tvalid && !m_tready) |-> !s_tready)
        else $error("tap accepted while pipeline is full");

    // The bottom cell is never negative: it is a raw tap reading.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !result.cell_one[scsm_pkg::CELL_BITS-1])
        else $error("bottom cell negative");
`endif

endmodule

FILE: rtl/scsm_cfg.sv
// APB register file holding the balance, over and under levels.
module scsm_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [scsm_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [scsm_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [scsm_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready,
    output scsm_pkg::cfg_t                     cfg
);

    scsm_pkg::cfg_t cfg_reg;
    scsm_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [1:0]     reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite & pready;
    assign reg_index = paddr[3:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_index)
                scsm_pkg::REG_BALANCE: begin
                    cfg_next.balance_level = pwdata[scsm_pkg::SAMPLE_BITS-1:0];
                end
                scsm_pkg::REG_OVER: begin
                    cfg_next.over_level = pwdata[scsm_pkg::SAMPLE_BITS-1:0];
                end
                scsm_pkg::REG_UNDER: begin
                    cfg_next.under_level = pwdata[scsm_pkg::CELL_BITS-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.balance_level <= scsm_pkg::BALANCE_RESET;
            cfg_reg.over_level    <= scsm_pkg::OVER_RESET;
            cfg_reg.under_level   <= scsm_pkg::UNDER_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_index)
            scsm_pkg::REG_BALANCE: begin
                prdata = scsm_pkg::APB_DATA_BITS'(cfg_reg.balance_level);
            end
            scsm_pkg::REG_OVER: begin
                prdata = scsm_pkg::APB_DATA_BITS'(cfg_reg.over_level);
            end
            scsm_pkg::REG_UNDER: begin
                prdata = scsm_pkg::APB_DATA_BITS'(cfg_reg.under_level);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/scsm_collect.sv
// Tap sequencer: turns four tap beats into one registered set of cell values.
module scsm_collect (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             tap_valid,
    output logic                             tap_ready,
    input  logic [scsm_pkg::SAMPLE_BITS-1:0] tap_sample,
    input  logic                             set_take,
    output logic                             set_valid,
    output scsm_pkg::cell_set_t              cell_set
);

    logic [1:0]                           tap_pos_reg;
    logic [1:0]                           tap_pos_next;
    logic [scsm_pkg::SAMPLE_BITS-1:0]     prev_tap_reg;
    logic [scsm_pkg::CELL_BITS-1:0]       store_reg [scsm_pkg::STORE_DEPTH];
    logic                                 set_valid_reg;
    logic                                 set_valid_next;
    scsm_pkg::cell_set_t                  set_reg;
    logic                                 tap_accept;
    logic                                 last_tap;
    logic [scsm_pkg::CELL_BITS-1:0]       diff;
    logic [scsm_pkg::CELL_BITS-1:0]       cell_value;

    assign tap_ready  = ~set_valid_reg | set_take;
    assign tap_accept = tap_valid & tap_ready;
    assign last_tap   = (tap_pos_reg == scsm_pkg::LAST_TAP);

    assign diff = {1'b0, tap_sample} - {1'b0, prev_tap_reg};
    // Bottom cell is the tap itself; the rest are differences.
    assign cell_value = (tap_pos_reg == 2'd0) ? {1'b0, tap_sample} : diff;

    always_comb begin
        tap_pos_next   = tap_pos_reg;
        set_valid_next = set_valid_reg;
        if (set_take) begin
            set_valid_next = 1'b0;
        end
        if (tap_accept) begin
            tap_pos_next = tap_pos_reg + 2'd1;
            if (last_tap) begin
                set_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_pos_reg   <= '0;
            prev_tap_reg  <= '0;
            set_valid_reg <= 1'b0;
        end else begin
            tap_pos_reg   <= tap_pos_next;
            set_valid_reg <= set_valid_next;
            if (tap_accept) begin
                prev_tap_reg <= tap_sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tap_accept) begin
            if (last_tap) begin
                set_reg.cells[0]    <= store_reg[0];
                set_reg.cells[1]    <= store_reg[1];
                set_reg.cells[2]    <= store_reg[2];
                set_reg.cells[3]    <= diff;
                set_reg.stack_level <= tap_sample;
            end else begin
                store_reg[tap_pos_reg] <= cell_value;
            end
        end
    end

    assign set_valid = set_valid_reg;
    assign cell_set  = set_reg;

endmodule

FILE: rtl/scsm_judge.sv
// Threshold checks on a cell set and the result register that feeds the output.
module scsm_judge (
    input  logic                aclk,
    input  logic                aresetn,
    input  scsm_pkg::cfg_t      cfg,
    input  logic                set_valid,
    output logic                set_take,
    input  scsm_pkg::cell_set_t cell_set,
    output logic                res_valid,
    input  logic                res_ready,
    output scsm_pkg::result_t   result
);

    logic                          res_valid_reg;
    logic                          res_valid_next;
    scsm_pkg::result_t             res_reg;
    scsm_pkg::result_t             res_next;
    logic                          load;
    logic [scsm_pkg::NUM_CELLS-1:0] is_top;
    logic [scsm_pkg::NUM_CELLS-1:0] is_over;
    logic                          active;
    logic [1:0]                    which;

    assign set_take = set_valid & (~res_valid_reg | res_ready);
    assign load     = set_take;

    // Mark a cell only when it beats every other cell strictly and the level.
    always_comb begin
        for (int i = 0; i < scsm_pkg::NUM_CELLS; i++) begin
            is_top[i] = $signed(cell_set.cells[i])
                        > $signed({1'b0, cfg.balance_level});
            is_over[i] = $signed(cell_set.cells[i])
                         > $signed({1'b0, cfg.over_level});
            for (int j = 0; j < scsm_pkg::NUM_CELLS; j++) begin
                if (j != i &&
                    !($signed(cell_set.cells[i]) > $signed(cell_set.cells[j]))) begin
                    is_top[i] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        active = 1'b0;
        which  = 2'd0;
        for (int i = 0; i < scsm_pkg::NUM_CELLS; i++) begin
            if (is_top[i]) begin
                active = 1'b1;
                which  = 2'(i);
            end
        end
    end

    always_comb begin
        res_next.cell_one       = cell_set.cells[0];
        res_next.cell_two       = cell_set.cells[1];
        res_next.cell_three     = cell_set.cells[2];
        res_next.cell_four      = cell_set.cells[3];
        res_next.stack_level    = cell_set.stack_level;
        res_next.balance_active = active;
        res_next.balance_cell   = which;
        res_next.over_voltage   = |is_over;
        res_next.under_voltage  = {1'b0, cell_set.stack_level} < cfg.under_level;
    end

    always_comb begin
        res_valid_next = res_valid_reg;
        if (res_ready) begin
            res_valid_next = 1'b0;
        end
        if (load) begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign result    = res_reg;

endmodule
